/* rtl/core/can_frame_to_ascii_serial_encoder_top_assert.svh */
// ----------------------------------------------------------------------------
// CAN frame ASCII encoder - assertion macros
// Shared concurrent assertion forms, reset-qualified, reporting by $error.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_TO_ASCII_SERIAL_ENCODER_TOP_ASSERT_SVH
`define CAN_FRAME_TO_ASCII_SERIAL_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define CFASE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFASE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cfase_pkg.sv */
// ----------------------------------------------------------------------------
// CAN frame ASCII encoder - package
// Types, codes and character helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfase_pkg;

    localparam int unsigned IdWidth      = 29;
    localparam int unsigned IdRegWidth   = 32;
    localparam int unsigned DataRegWidth = 64;
    localparam int unsigned CntWidth     = 5;

    localparam logic [3:0]          MaxLen       = 4'd8;
    localparam logic [CntWidth-1:0] IdLastStd    = 5'd2;
    localparam logic [CntWidth-1:0] IdLastExt    = 5'd7;

    localparam logic [7:0] ChStdData = 8'h74;  // t
    localparam logic [7:0] ChStdRtr  = 8'h72;  // r
    localparam logic [7:0] ChExtData = 8'h54;  // T
    localparam logic [7:0] ChExtRtr  = 8'h52;  // R
    localparam logic [7:0] ChCr      = 8'h0D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KIND,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_CR
    } state_t;

    typedef enum logic [2:0] {
        SRC_KIND,
        SRC_ID,
        SRC_LEN,
        SRC_DATA,
        SRC_CR
    } src_t;

    typedef struct packed {
        logic load;
        logic emit;
        src_t src;
        logic last;
    } seq_ctrl_t;

    function automatic logic [3:0] sat_len(input logic [3:0] len);
        sat_len = (len > MaxLen) ? MaxLen : len;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            hex_char = 8'h30 + {4'b0, nib};
        else
            hex_char = 8'h37 + {4'b0, nib};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cfase_if.sv */
// ----------------------------------------------------------------------------
// CAN frame ASCII encoder - channel interfaces
// Frame input channel and character output channel, valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfase_frame_if;
    logic        valid;
    logic        ready;
    logic        is_extended;
    logic        is_remote;
    logic [28:0] can_id;
    logic [3:0]  data_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;

    modport source (
        output valid, is_extended, is_remote, can_id, data_len,
               byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        input  ready
    );
    modport sink (
        input  valid, is_extended, is_remote, can_id, data_len,
               byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
        output ready
    );
endinterface

interface cfase_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       is_last;

    modport source (output valid, out_char, is_last, input ready);
    modport sink (input valid, out_char, is_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfase_seq.sv */
// ----------------------------------------------------------------------------
// CAN frame ASCII encoder - sequencer
// Steps through type, identifier, length, data and CR characters.
// ----------------------------------------------------------------------------
`default_nettype none

module cfase_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               frame_valid,
    input  wire logic               is_extended,
    input  wire logic [3:0]         data_len,
    input  wire logic               go,
    output logic                    in_ready,
    output cfase_pkg::seq_ctrl_t    ctrl
);
    import cfase_pkg::*;

    state_t              state_reg, state_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic [3:0]          len_reg, len_next;
    logic                ext_reg, ext_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            len_reg   <= '0;
            ext_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            ext_reg   <= ext_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        ext_next   = ext_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid)
                begin
                    state_next = ST_KIND;
                    len_next   = sat_len(data_len);
                    ext_next   = is_extended;
                end
            end
            ST_KIND:
            begin
                if (go)
                begin
                    state_next = ST_ID;
                    cnt_next   = ext_reg ? IdLastExt : IdLastStd;
                end
            end
            ST_ID:
            begin
                if (go)
                begin
                    if (cnt_reg == '0)
                        state_next = ST_LEN;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_LEN:
            begin
                if (go)
                begin
                    if (len_reg == '0)
                        state_next = ST_CR;
                    else
                    begin
                        state_next = ST_DATA;
                        cnt_next   = {len_reg, 1'b0} - 1'b1;
                    end
                end
            end
            ST_DATA:
            begin
                if (go)
                begin
                    if (cnt_reg == '0)
                        state_next = ST_CR;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CR:
            begin
                if (go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        ctrl.load = 1'b0;
        ctrl.emit = 1'b0;
        ctrl.src  = SRC_KIND;
        ctrl.last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = frame_valid;
            end
            ST_KIND:
            begin
                ctrl.emit = go;
                ctrl.src  = SRC_KIND;
            end
            ST_ID:
            begin
                ctrl.emit = go;
                ctrl.src  = SRC_ID;
            end
            ST_LEN:
            begin
                ctrl.emit = go;
                ctrl.src  = SRC_LEN;
            end
            ST_DATA:
            begin
                ctrl.emit = go;
                ctrl.src  = SRC_DATA;
            end
            ST_CR:
            begin
                ctrl.emit = go;
                ctrl.src  = SRC_CR;
                ctrl.last = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/cfase_datapath.sv */
// ----------------------------------------------------------------------------
// CAN frame ASCII encoder - datapath
// Frame shift registers, shared nibble-to-hex unit and character register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfase_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfase_pkg::seq_ctrl_t   ctrl,
    input  wire logic                   is_extended,
    input  wire logic                   is_remote,
    input  wire logic [28:0]            can_id,
    input  wire logic [3:0]             data_len,
    input  wire logic [63:0]            data_bytes,
    input  wire logic                   out_ready,
    output logic                        go,
    output logic                        out_valid,
    output logic [7:0]                  out_char,
    output logic                        out_last
);
    import cfase_pkg::*;

    logic [IdRegWidth-1:0]   id_reg;
    logic [DataRegWidth-1:0] data_reg;
    logic [7:0]              kind_reg;
    logic [3:0]              len_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_char_reg;
    logic                    out_last_reg;
    logic [3:0]              nib;
    logic [7:0]              char_next;

    assign go = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            if (is_extended)
            begin
                id_reg   <= {3'b0, can_id};
                kind_reg <= is_remote ? ChExtRtr : ChExtData;
            end
            else
            begin
                id_reg   <= {1'b0, can_id[10:0], 20'b0};
                kind_reg <= is_remote ? ChStdRtr : ChStdData;
            end
            data_reg <= data_bytes;
            len_reg  <= sat_len(data_len);
        end
        else if (ctrl.emit)
        begin
            if (ctrl.src == SRC_ID)
                id_reg <= {id_reg[IdRegWidth-5:0], 4'b0};
            if (ctrl.src == SRC_DATA)
                data_reg <= {data_reg[DataRegWidth-5:0], 4'b0};
        end
    end

    always_comb
    begin
        case (ctrl.src)
            SRC_ID:   nib = id_reg[IdRegWidth-1 -: 4];
            SRC_DATA: nib = data_reg[DataRegWidth-1 -: 4];
            default:  nib = len_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.src)
            SRC_KIND: char_next = kind_reg;
            SRC_CR:   char_next = ChCr;
            default:  char_next = hex_char(nib);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            out_char_reg <= char_next;
            out_last_reg <= ctrl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

/* rtl/core/can_frame_to_ascii_serial_encoder_top.sv */
// The type character is offered once the sequencer has entered its type
// state and the output register is free and has taken it.
// Frames are taken one at a time: a new frame is accepted only when the
// sequencer is back in idle after the CR, with len saturated to 8. The single
// character register and its hex unit take one character per cycle unless the output stalls.
// Reset: rst_n low clears the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// CAN frame ASCII encoder - top level
// Turns one CAN frame into its ASCII serial-line text, one character a transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_to_ascii_serial_encoder_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfase_frame_if.sink frame,
    cfase_char_if.source text
);
    import cfase_pkg::*;

    `include "can_frame_to_ascii_serial_encoder_top_assert.svh"

    seq_ctrl_t ctrl;
    logic      go;
    logic      in_ready;

    cfase_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .is_extended (frame.is_extended),
        .data_len    (frame.data_len),
        .go          (go),
        .in_ready    (in_ready),
        .ctrl        (ctrl)
    );

    cfase_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .is_extended (frame.is_extended),
        .is_remote   (frame.is_remote),
        .can_id      (frame.can_id),
        .data_len    (frame.data_len),
        .data_bytes  ({frame.byte0, frame.byte1, frame.byte2, frame.byte3,
                       frame.byte4, frame.byte5, frame.byte6, frame.byte7}),
        .out_ready   (text.ready),
        .go          (go),
        .out_valid   (text.valid),
        .out_char    (text.out_char),
        .out_last    (text.is_last)
    );

    assign frame.ready = in_ready;

    `CFASE_ASSERT_NEXT(a_busy_after_frame, clk, rst_n,
        frame.valid && frame.ready, !frame.ready, "frame taken while busy")
    `CFASE_ASSERT_NEXT(a_char_held_stalled, clk, rst_n,
        text.valid && !text.ready,
        text.valid && $stable(text.out_char) && $stable(text.is_last),
        "character changed while stalled")
    `CFASE_ASSERT_NEXT(a_cr_marked_last, clk, rst_n,
        ctrl.emit && (ctrl.src == SRC_CR),
        text.valid && text.is_last && (text.out_char == ChCr),
        "closing CR not presented as last")

endmodule

`default_nettype wire
